>>> rtl/core/st_pkg.sv
// Package for the source tokenizer: token kinds, scan modes, character classes and keyword lookup.
package st_pkg;

  localparam int unsigned PositionBits       = 16;
  localparam int unsigned KeywordPrefixDepth = 7;
  localparam int unsigned MaxResults         = 3;

  typedef enum logic [3:0] {
    MODE_IDLE     = 4'd0,
    MODE_IDENT    = 4'd1,
    MODE_NUM_INT  = 4'd2,
    MODE_NUM_DOT  = 4'd3,
    MODE_NUM_FRAC = 4'd4,
    MODE_STRING   = 4'd5,
    MODE_OP1      = 4'd6,
    MODE_OP2      = 4'd7
  } scan_mode_e;

  localparam logic [6:0] KindDot      = 7'd7;
  localparam logic [6:0] KindStrLit   = 7'd45;
  localparam logic [6:0] KindNumber   = 7'd46;
  localparam logic [6:0] KindIdent    = 7'd69;
  localparam logic [6:0] KindError    = 7'd70;
  localparam logic [6:0] KindEnd      = 7'd71;
  localparam logic [6:0] KindNotPunct = 7'h7f;

  localparam logic [1:0] ErrNone       = 2'd0;
  localparam logic [1:0] ErrUnexpected = 2'd1;
  localparam logic [1:0] ErrUntermStr  = 2'd2;

  typedef struct packed {
    logic [6:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic [1:0]  err;
  } token_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Punctuation kind, or KindNotPunct when not punctuation.
  function automatic logic [6:0] punct_kind(input logic [7:0] c);
    logic [6:0] k;
    case (c)
      "(": k = 7'd0;  ")": k = 7'd1;  "{": k = 7'd2;  "}": k = 7'd3;
      "[": k = 7'd4;  "]": k = 7'd5;  ",": k = 7'd6;  ".": k = 7'd7;
      ";": k = 7'd8;  ":": k = 7'd9;  "~": k = 7'd10; "?": k = 7'd11;
      "$": k = 7'd12;
      default: k = KindNotPunct;
    endcase
    return k;
  endfunction

  // Single-character operator kind; error kind when not an operator.
  function automatic logic [6:0] op_single(input logic [7:0] c);
    logic [6:0] k;
    case (c)
      "+": k = 7'd13; "-": k = 7'd16; "*": k = 7'd19; "/": k = 7'd21;
      "%": k = 7'd23; "!": k = 7'd25; "=": k = 7'd27; ">": k = 7'd29;
      "<": k = 7'd33; "&": k = 7'd37; "|": k = 7'd40; "^": k = 7'd43;
      default: k = KindError;
    endcase
    return k;
  endfunction

  function automatic logic op_has_second(input logic [7:0] c);
    return c == "+" || c == "-" || c == ">" || c == "<" || c == "&" || c == "|";
  endfunction

  // Keyword lookup over the first seven prefix bytes; len already limited to seven.
  function automatic logic [6:0] keyword_kind(input logic [7:0] p [7], input logic [2:0] len);
    logic [6:0] k;
    k = KindIdent;
    case (len)
      3'd2: begin
        if (p[0] == "f" && p[1] == "n") k = 7'd54;
        if (p[0] == "i" && p[1] == "f") k = 7'd55;
        if (p[0] == "i" && p[1] == "n") k = 7'd56;
        if (p[0] == "o" && p[1] == "r") k = 7'd42;
      end
      3'd3: begin
        if (p[0] == "a" && p[1] == "n" && p[2] == "d") k = 7'd39;
        if (p[0] == "a" && p[1] == "n" && p[2] == "y") k = 7'd47;
        if (p[0] == "f" && p[1] == "o" && p[2] == "r") k = 7'd53;
        if (p[0] == "i" && p[1] == "n" && p[2] == "t") k = 7'd57;
        if (p[0] == "n" && p[1] == "i" && p[2] == "l") k = 7'd58;
        if (p[0] == "n" && p[1] == "u" && p[2] == "m") k = 7'd46;
        if (p[0] == "v" && p[1] == "a" && p[2] == "r") k = 7'd67;
      end
      3'd4: begin
        if ({p[0], p[1], p[2], p[3]} == "bool") k = 7'd48;
        if ({p[0], p[1], p[2], p[3]} == "case") k = 7'd49;
        if ({p[0], p[1], p[2], p[3]} == "else") k = 7'd51;
        if ({p[0], p[1], p[2], p[3]} == "self") k = 7'd61;
        if ({p[0], p[1], p[2], p[3]} == "skip") k = 7'd64;
        if ({p[0], p[1], p[2], p[3]} == "true") k = 7'd65;
        if ({p[0], p[1], p[2], p[3]} == "type") k = 7'd66;
      end
      3'd5: begin
        if ({p[0], p[1], p[2], p[3], p[4]} == "false") k = 7'd52;
        if ({p[0], p[1], p[2], p[3], p[4]} == "print") k = 7'd59;
        if ({p[0], p[1], p[2], p[3], p[4]} == "while") k = 7'd68;
      end
      3'd6: begin
        if ({p[0], p[1], p[2], p[3], p[4], p[5]} == "return") k = 7'd60;
        if ({p[0], p[1], p[2], p[3], p[4], p[5]} == "static") k = 7'd62;
        if ({p[0], p[1], p[2], p[3], p[4], p[5]} == "string") k = 7'd63;
        if ({p[0], p[1], p[2], p[3], p[4], p[5]} == "switch") k = 7'd64;
      end
      3'd7: begin
        if ({p[0], p[1], p[2], p[3], p[4], p[5], p[6]} == "default") k = 7'd50;
      end
      default: k = KindIdent;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/core/st_scan.sv
// Scanner state and per-byte token decision; one byte per cycle while step_i is high.
module st_scan #(
  parameter int unsigned POSITION_BITS        = st_pkg::PositionBits,
  parameter int unsigned KEYWORD_PREFIX_DEPTH = st_pkg::KeywordPrefixDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        char_i,
  input  logic              eos_i,
  output logic [1:0]        count_o,
  output st_pkg::token_t    tok_o [3]
);

  localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};
  localparam int unsigned PrefixIdxBits = $clog2(KEYWORD_PREFIX_DEPTH);
  localparam int unsigned SumBits = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 1;

  st_pkg::scan_mode_e        mode_q, mode_d;
  logic [POSITION_BITS-1:0]  pos_q, pos_d, begin_q, begin_d;
  logic [15:0]               line_q, line_d, len_q, len_d;
  logic [7:0]                pend_q, pend_d;
  logic                      esc_q, esc_d;
  logic [7:0]                prefix_q [KEYWORD_PREFIX_DEPTH];
  logic                      pwr;
  logic [PrefixIdxBits-1:0]  pidx;
  logic [7:0]                pwr_data;

  logic [7:0]  kwp [7];
  logic [6:0]  id_kind, single;
  logic [1:0]  n;
  st_pkg::token_t t [3];
  logic        start_tok;
  logic [15:0] begin16, dot16;
  logic [SumBits-1:0] dot_sum;

  function automatic logic [15:0] inc16(input logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] clamp16(input logic [POSITION_BITS-1:0] v);
    return (v > POSITION_BITS'(16'hffff)) ? 16'hffff : 16'(v);
  endfunction

  always_comb begin
    for (int i = 0; i < 7; i++) kwp[i] = prefix_q[i];
    id_kind = (len_q > 16'(KEYWORD_PREFIX_DEPTH) || len_q > 16'd7) ? st_pkg::KindIdent
            : st_pkg::keyword_kind(kwp, len_q[2:0]);
    single  = st_pkg::op_single(pend_q);
    begin16 = clamp16(begin_q);
    dot_sum = SumBits'(begin_q) + SumBits'(len_q);
    dot16   = (dot_sum > SumBits'(PosMax)) ? clamp16(PosMax)
            : clamp16(dot_sum[POSITION_BITS-1:0]);
  end

  // Emits append into t[n]; the branches below emit at most three tokens per byte.
  always_comb begin
    mode_d = mode_q; pos_d = pos_q; begin_d = begin_q; line_d = line_q;
    len_d = len_q; pend_d = pend_q; esc_d = esc_q;
    pwr = 1'b0; pidx = '0; pwr_data = char_i;
    n = 2'd0; start_tok = 1'b0;
    for (int i = 0; i < 3; i++) t[i] = '0;

    if (eos_i) begin
      case (mode_q)
        st_pkg::MODE_IDENT: begin
          t[0] = '{id_kind, begin16, len_q, line_q, st_pkg::ErrNone}; n = 2'd1;
        end
        st_pkg::MODE_NUM_INT, st_pkg::MODE_NUM_FRAC: begin
          t[0] = '{st_pkg::KindNumber, begin16, len_q, line_q, st_pkg::ErrNone}; n = 2'd1;
        end
        st_pkg::MODE_NUM_DOT: begin
          t[0] = '{st_pkg::KindNumber, begin16, len_q, line_q, st_pkg::ErrNone};
          t[1] = '{st_pkg::KindDot, dot16, 16'd1, line_q, st_pkg::ErrNone}; n = 2'd2;
        end
        st_pkg::MODE_STRING: begin
          t[0] = '{st_pkg::KindError, begin16, len_q, line_q, st_pkg::ErrUntermStr}; n = 2'd1;
        end
        st_pkg::MODE_OP1: begin
          t[0] = '{single, begin16, 16'd1, line_q, st_pkg::ErrNone}; n = 2'd1;
        end
        st_pkg::MODE_OP2: begin
          t[0] = '{single + 7'd2, begin16, 16'd2, line_q, st_pkg::ErrNone}; n = 2'd1;
        end
        default: n = 2'd0;
      endcase
      t[n] = '{st_pkg::KindEnd, clamp16(pos_q), 16'd0, line_q, st_pkg::ErrNone};
      n = n + 2'd1;
      mode_d = st_pkg::MODE_IDLE;
      esc_d  = 1'b0;
    end else begin
      if (pos_q != PosMax) pos_d = pos_q + POSITION_BITS'(1);
      case (mode_q)
        st_pkg::MODE_IDENT: begin
          if (st_pkg::is_alpha(char_i) || st_pkg::is_digit(char_i)) begin
            if (len_q < 16'(KEYWORD_PREFIX_DEPTH)) begin
              pwr = 1'b1; pidx = len_q[PrefixIdxBits-1:0];
            end
            len_d = inc16(len_q);
          end else begin
            t[0] = '{id_kind, begin16, len_q, line_q, st_pkg::ErrNone}; n = 2'd1;
            start_tok = 1'b1;
          end
        end
        st_pkg::MODE_NUM_INT: begin
          if (st_pkg::is_digit(char_i)) len_d = inc16(len_q);
          else if (char_i == ".") mode_d = st_pkg::MODE_NUM_DOT;
          else begin
            t[0] = '{st_pkg::KindNumber, begin16, len_q, line_q, st_pkg::ErrNone}; n = 2'd1;
            start_tok = 1'b1;
          end
        end
        st_pkg::MODE_NUM_DOT: begin
          if (st_pkg::is_digit(char_i)) begin
            len_d  = inc16(inc16(len_q));
            mode_d = st_pkg::MODE_NUM_FRAC;
          end else begin
            t[0] = '{st_pkg::KindNumber, begin16, len_q, line_q, st_pkg::ErrNone};
            t[1] = '{st_pkg::KindDot, dot16, 16'd1, line_q, st_pkg::ErrNone}; n = 2'd2;
            start_tok = 1'b1;
          end
        end
        st_pkg::MODE_NUM_FRAC: begin
          if (st_pkg::is_digit(char_i)) len_d = inc16(len_q);
          else begin
            t[0] = '{st_pkg::KindNumber, begin16, len_q, line_q, st_pkg::ErrNone}; n = 2'd1;
            start_tok = 1'b1;
          end
        end
        st_pkg::MODE_STRING: begin
          len_d = inc16(len_q);
          if (esc_q) esc_d = 1'b0;
          else if (char_i == "\\") esc_d = 1'b1;
          else if (char_i == "\"") begin
            t[0] = '{st_pkg::KindStrLit, begin16, inc16(len_q), line_q, st_pkg::ErrNone};
            n = 2'd1; mode_d = st_pkg::MODE_IDLE;
          end else if (char_i == 8'h0a) line_d = inc16(line_q);
        end
        st_pkg::MODE_OP1: begin
          if (char_i == "=") begin
            t[0] = '{single + 7'd1, begin16, 16'd2, line_q, st_pkg::ErrNone};
            n = 2'd1; mode_d = st_pkg::MODE_IDLE;
          end else if (char_i == pend_q && st_pkg::op_has_second(char_i)) begin
            if (char_i == ">" || char_i == "<") mode_d = st_pkg::MODE_OP2;
            else begin
              t[0] = '{single + 7'd2, begin16, 16'd2, line_q, st_pkg::ErrNone};
              n = 2'd1; mode_d = st_pkg::MODE_IDLE;
            end
          end else begin
            t[0] = '{single, begin16, 16'd1, line_q, st_pkg::ErrNone}; n = 2'd1;
            start_tok = 1'b1;
          end
        end
        st_pkg::MODE_OP2: begin
          if (char_i == "=") begin
            t[0] = '{single + 7'd3, begin16, 16'd3, line_q, st_pkg::ErrNone};
            n = 2'd1; mode_d = st_pkg::MODE_IDLE;
          end else begin
            t[0] = '{single + 7'd2, begin16, 16'd2, line_q, st_pkg::ErrNone}; n = 2'd1;
            start_tok = 1'b1;
          end
        end
        default: start_tok = 1'b1;
      endcase

      if (start_tok) begin
        mode_d = st_pkg::MODE_IDLE;
        if (char_i == " " || char_i == 8'h0d || char_i == 8'h09) begin
          mode_d = st_pkg::MODE_IDLE;
        end else if (char_i == 8'h0a) begin
          line_d = inc16(line_q);
        end else begin
          begin_d = pos_q;
          len_d   = 16'd1;
          if (st_pkg::is_alpha(char_i)) begin
            pwr = 1'b1; pidx = '0; mode_d = st_pkg::MODE_IDENT;
          end else if (st_pkg::is_digit(char_i)) begin
            mode_d = st_pkg::MODE_NUM_INT;
          end else if (char_i == "\"") begin
            esc_d = 1'b0; mode_d = st_pkg::MODE_STRING;
          end else if (st_pkg::punct_kind(char_i) != st_pkg::KindNotPunct) begin
            t[n] = '{st_pkg::punct_kind(char_i), clamp16(pos_q), 16'd1, line_q,
                     st_pkg::ErrNone};
            n = n + 2'd1;
          end else if (st_pkg::op_single(char_i) != st_pkg::KindError) begin
            pend_d = char_i; mode_d = st_pkg::MODE_OP1;
          end else if (char_i == 8'h00) begin
            t[n] = '{st_pkg::KindEnd, clamp16(pos_q), 16'd1, line_q, st_pkg::ErrNone};
            n = n + 2'd1;
          end else begin
            t[n] = '{st_pkg::KindError, clamp16(pos_q), 16'd1, line_q,
                     st_pkg::ErrUnexpected};
            n = n + 2'd1;
          end
        end
      end
    end
  end

  assign count_o = n;
  assign tok_o   = t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= st_pkg::MODE_IDLE;
      pos_q   <= '0;
      begin_q <= '0;
      line_q  <= 16'd1;
      len_q   <= '0;
      pend_q  <= '0;
      esc_q   <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      begin_q <= begin_d;
      line_q  <= line_d;
      len_q   <= len_d;
      pend_q  <= pend_d;
      esc_q   <= esc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && pwr) prefix_q[pidx] <= pwr_data;
  end

endmodule

>>> rtl/core/st_outq.sv
// Result queue: eight entries, takes up to three tokens per byte, drains one a cycle while ready_i is high.
module st_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [1:0]     count_i,
  input  st_pkg::token_t tok_i [3],
  output logic           space_o,
  output logic           valid_o,
  input  logic           ready_i,
  output st_pkg::token_t tok_o,
  output logic           last_o
);

  localparam int unsigned Depth = 8;

  st_pkg::token_t mem_q [Depth];
  logic           last_q [Depth];
  logic [2:0]     rd_q, wr_q;
  logic [3:0]     fill_q;
  logic           pop;
  logic [1:0]     add;

  assign valid_o = fill_q != 4'd0;
  assign pop     = valid_o && ready_i;
  assign add     = push_i ? count_i : 2'd0;
  // Room for a full byte's worth even when nothing pops this cycle.
  assign space_o = fill_q <= 4'd5;
  assign tok_o   = mem_q[rd_q];
  assign last_o  = last_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q   <= '0;
      wr_q   <= '0;
      fill_q <= '0;
    end else begin
      if (pop) rd_q <= rd_q + 3'd1;
      wr_q   <= wr_q + 3'(add);
      fill_q <= fill_q + 4'(add) - 4'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < add) begin
        mem_q[wr_q + 3'(i)]  <= tok_i[i];
        last_q[wr_q + 3'(i)] <= (2'(i) == add - 2'd1);
      end
    end
  end

endmodule

>>> rtl/core/source_tokenizer.sv
// Top level of the streaming source tokenizer.
// Usage: one source byte per transfer on the s_axis side; tdata[7:0] is the byte and
// tuser flags end of text (byte then ignored, pending token flushed, end token added).
// Each byte yields zero to three tokens on the m_axis side; tlast marks the final token
// caused by one input byte. Blanks yield nothing; newlines advance the line count.
// A token is written into the output queue when the byte that completes it is taken.
// Throughput: one byte per cycle while s_axis_tready is high; the scan state is registered.
// Tokens drain one per cycle while m_axis_tready is high through an 8-entry queue, so a run
// of multi-token bytes can briefly drop s_axis_tready until the queue has room for three more.
// Reset: scan state idle, offset 0, line 1, queue empty; no clearing pass.
// When the receiver stalls the queue fills and s_axis_tready falls; nothing is lost.
module source_tokenizer #(
  parameter int unsigned POSITION_BITS        = st_pkg::PositionBits,
  parameter int unsigned KEYWORD_PREFIX_DEPTH = st_pkg::KeywordPrefixDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] source_char
  input  logic        s_axis_tuser,  // [0] end_of_source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // token_kind, token_start, token_length, line_number, error_code
  output logic        m_axis_tlast
);

  logic           step;
  logic [1:0]     count;
  st_pkg::token_t toks [3];
  st_pkg::token_t head;
  logic           space;

  assign s_axis_tready = space;
  assign step = s_axis_tvalid && s_axis_tready;

  st_scan #(
    .POSITION_BITS(POSITION_BITS),
    .KEYWORD_PREFIX_DEPTH(KEYWORD_PREFIX_DEPTH)
  ) u_scan (
    .clk_i, .rst_ni, .step_i(step), .char_i(s_axis_tdata), .eos_i(s_axis_tuser),
    .count_o(count), .tok_o(toks)
  );

  st_outq u_outq (
    .clk_i, .rst_ni, .push_i(step), .count_i(count), .tok_i(toks), .space_o(space),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .tok_o(head), .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {7'b0, head.err, head.line, head.length, head.start, head.kind};

  a_eos_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && s_axis_tuser |-> count != 2'd0) else $error("end marker without end token");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> count != 2'd3 || s_axis_tuser || toks[2].kind != st_pkg::KindIdent)
    else $error("third token is never an identifier");
  a_valid_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && count != 2'd0 |=> m_axis_tvalid) else $error("token lost");

endmodule
